// ===== rtl/core/wcwt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and constant-divide helpers for the week clock.
package wcwt_pkg;

  localparam logic [7:0]  TicksPerSecond = 8'd217;
  localparam logic [13:0] MinutesPerWeek = 14'd10080;
  localparam logic [13:0] MinutesPerDay  = 14'd1440;
  localparam logic [13:0] SetTimeOffset  = 14'd480;
  localparam logic [13:0] EarlyWrapBase  = 14'd9660;
  localparam logic [13:0] EarlyLimit     = 14'd300;
  localparam logic [5:0]  SecondsRoll    = 6'd60;
  localparam logic [5:0]  SkipRoll       = 6'd60;
  localparam logic [2:0]  EarlyDay       = 3'd6;

  // Reciprocals for floor division by small constants; exact over the input widths used.
  localparam logic [14:0] Div30Mul = 15'd17477;   // 2^19 / 30, rounded up
  localparam logic [17:0] Div60Mul = 18'd139811;  // 2^23 / 60, rounded up
  localparam logic [14:0] Div25Mul = 15'd20972;   // 2^19 / 25, rounded up

  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_SET_TIME    = 3'd1,
    MODE_SET_TIMEOUT = 3'd2,
    MODE_QUERY       = 3'd3,
    MODE_WRITE_FLAG  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [15:0] delay_seconds;
    logic [13:0] query_minute;
    logic        flag_value;
  } item_t;

  typedef struct packed {
    logic        timed_out;
    logic [5:0]  second;
    logic [13:0] minute;
    logic        update_flag;
    logic        led_off_pulse;
  } status_t;

  function automatic logic [9:0] div30(input logic [13:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(Div30Mul);
    return p[28:19];
  endfunction

  function automatic logic [10:0] div60(input logic [15:0] x);
    logic [33:0] p;
    p = 34'(x) * 34'(Div60Mul);
    return p[33:23];
  endfunction

  function automatic logic [4:0] mod25(input logic [13:0] x);
    logic [28:0] p;
    logic [13:0] q25;
    p   = 29'(x) * 29'(Div25Mul);
    q25 = 14'(p[28:19]) * 14'd25;
    return 5'(x - q25);
  endfunction

endpackage

// ===== rtl/core/wcwt_input_stage.sv =====
`timescale 1ns / 1ps
// Input register: holds one accepted beat until the clock core takes it.
module wcwt_input_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wcwt_pkg::item_t in_item_i,
  input  logic          advance_i,
  output logic          item_valid_o,
  output wcwt_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  wcwt_pkg::item_t item_q;
  logic            take;

  // Hold the beat only while the result side cannot move.
  assign in_stall_o = valid_q & ~advance_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/wcwt_clock_core.sv =====
`timescale 1ns / 1ps
// Clock state: tick divider, seconds, minutes, drift skip, deadline and update flag.
module wcwt_clock_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  wcwt_pkg::item_t   item_i,
  output logic [2:0]        day_next_o,
  output wcwt_pkg::status_t status_o
);

  logic [7:0]  div_q, div_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  skip_q, skip_d;
  logic [13:0] min_q, min_d;
  logic [2:0]  day_q, day_d;
  logic [5:0]  dsec_q, dsec_d;
  logic [13:0] dmin_q, dmin_d;
  logic        flag_q, flag_d;
  logic        pulse_q, pulse_d;

  logic [5:0]  sec_inc;
  logic [13:0] total;
  logic [10:0] delay_min;
  logic [5:0]  delay_rem;
  logic [6:0]  sec_sum;
  logic        carry;
  logic        min_wraps;

  assign sec_inc   = sec_q + 6'd1;
  assign total     = 14'(14'(item_i.set_day) * wcwt_pkg::MinutesPerDay)
                   + 14'(14'(item_i.set_hour) * 14'd60) + 14'(item_i.set_minute);
  assign delay_min = wcwt_pkg::div60(item_i.delay_seconds);
  assign delay_rem = 6'(item_i.delay_seconds - 16'(delay_min) * 16'd60);
  assign sec_sum   = 7'(sec_q) + 7'(delay_rem);
  assign carry     = (sec_sum > 7'd59);
  assign min_wraps = (min_q == wcwt_pkg::MinutesPerWeek) || (min_q == 14'h3FFF);

  always_comb begin
    div_d   = div_q;
    sec_d   = sec_q;
    skip_d  = skip_q;
    min_d   = min_q;
    day_d   = day_q;
    dsec_d  = dsec_q;
    dmin_d  = dmin_q;
    flag_d  = flag_q;
    pulse_d = 1'b0;
    case (wcwt_pkg::mode_e'(item_i.mode))
      wcwt_pkg::MODE_TICK: begin
        if (div_q != wcwt_pkg::TicksPerSecond) begin
          div_d = div_q + 8'd1;
        end else begin
          div_d = '0;
          if (sec_q == wcwt_pkg::SecondsRoll) begin
            sec_d = '0;
            if (skip_q == wcwt_pkg::SkipRoll) begin
              skip_d = '0;
            end else begin
              skip_d = skip_q + 6'd1;
              // New minute is zero on wrap, else min+1; test divisibility on the old value.
              if (min_q == wcwt_pkg::MinutesPerWeek) begin
                min_d = '0;
              end else begin
                min_d = min_q + 14'd1;
              end
              if (min_wraps || (wcwt_pkg::mod25(min_q) == 5'd24)) begin
                flag_d = 1'b0;
              end
            end
          end else begin
            sec_d   = sec_inc;
            pulse_d = (sec_inc inside {6'd0, 6'd20, 6'd40, 6'd60});
          end
        end
      end
      wcwt_pkg::MODE_SET_TIME: begin
        if (total >= wcwt_pkg::EarlyLimit) begin
          min_d = total - wcwt_pkg::SetTimeOffset;
        end else begin
          min_d = wcwt_pkg::EarlyWrapBase + total;
          day_d = wcwt_pkg::EarlyDay;
        end
        sec_d = item_i.set_second;
      end
      wcwt_pkg::MODE_SET_TIMEOUT: begin
        dsec_d = carry ? 6'(sec_sum - 7'd60) : 6'(sec_sum);
        dmin_d = min_q + 14'(delay_min) + 14'(carry);
      end
      wcwt_pkg::MODE_WRITE_FLAG: begin
        flag_d = item_i.flag_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= '0;
      sec_q   <= '0;
      skip_q  <= 6'd1;
      min_q   <= '0;
      day_q   <= '0;
      dsec_q  <= '0;
      dmin_q  <= '0;
      flag_q  <= 1'b1;
      pulse_q <= 1'b0;
    end else if (load_i) begin
      div_q   <= div_d;
      sec_q   <= sec_d;
      skip_q  <= skip_d;
      min_q   <= min_d;
      day_q   <= day_d;
      dsec_q  <= dsec_d;
      dmin_q  <= dmin_d;
      flag_q  <= flag_d;
      pulse_q <= pulse_d;
    end
  end

  assign day_next_o             = day_d;
  assign status_o.timed_out     = (sec_q >= dsec_q) && (min_q >= dmin_q);
  assign status_o.second        = sec_q;
  assign status_o.minute        = min_q;
  assign status_o.update_flag   = flag_q;
  assign status_o.led_off_pulse = pulse_q;

endmodule

// ===== rtl/core/wcwt_block_calc.sv =====
`timescale 1ns / 1ps
// Thirty-minute block of a queried week minute, truncated toward zero, low eight bits.
module wcwt_block_calc (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [13:0] query_minute_i,
  input  logic [2:0]  day_i,
  output logic [7:0]  block_index_o
);

  logic [13:0]        day_min;
  logic signed [14:0] diff;
  logic [13:0]        mag;
  logic [9:0]         quot;
  logic [7:0]         block_q;

  assign day_min = 14'(14'(day_i) * wcwt_pkg::MinutesPerDay);
  assign diff    = $signed({1'b0, query_minute_i}) - $signed({1'b0, day_min});
  assign mag     = diff[14] ? 14'(-diff) : diff[13:0];
  assign quot    = wcwt_pkg::div30(mag);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      block_q <= diff[14] ? 8'(-quot) : quot[7:0];
    end
  end

  assign block_index_o = block_q;

endmodule

// ===== rtl/core/week_clock_with_timeout.sv =====
`timescale 1ns / 1ps
// Top level of the minute-of-week clock with timeout deadline and block query.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_stall_o | mode, set time, delay, query, flag
//   out     | output    | out_valid_o/out_stall_i | timed_out, second, minute, flag, led, block
//
// One beat per cycle sustained while the result side does not stall; a taken beat is held
// in the input register, then loads the state and result registers, where it is offered.
// The clock state registers are the result register: they load when a beat moves on.
// Reset clears the handshake and the clock state to its power-up values.
// A stall on the result side holds the state and result, and in_stall_o rises only
// once the input register is also full.
module week_clock_with_timeout (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [2:0]  set_day_i,
  input  logic [4:0]  set_hour_i,
  input  logic [5:0]  set_minute_i,
  input  logic [5:0]  set_second_i,
  input  logic [15:0] delay_seconds_i,
  input  logic [13:0] query_minute_i,
  input  logic        flag_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        timed_out_o,
  output logic [5:0]  current_second_o,
  output logic [13:0] current_minute_o,
  output logic        update_pending_o,
  output logic        led_off_pulse_o,
  output logic [7:0]  block_index_o
);

  wcwt_pkg::item_t   in_item;
  wcwt_pkg::item_t   item;
  wcwt_pkg::status_t status;
  logic              item_valid;
  logic              advance;
  logic              load;
  logic [2:0]        day_next;
  logic              out_valid_q, out_valid_d;

  assign in_item.mode          = mode_i;
  assign in_item.set_day       = set_day_i;
  assign in_item.set_hour      = set_hour_i;
  assign in_item.set_minute    = set_minute_i;
  assign in_item.set_second    = set_second_i;
  assign in_item.delay_seconds = delay_seconds_i;
  assign in_item.query_minute  = query_minute_i;
  assign in_item.flag_value    = flag_value_i;

  // The result slot can move when it is empty or being taken this cycle.
  assign advance = ~out_valid_q | ~out_stall_i;
  assign load    = advance & item_valid;

  wcwt_input_stage u_input (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wcwt_clock_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .item_i     (item),
    .day_next_o (day_next),
    .status_o   (status)
  );

  // Block query uses the day base as it stands after this beat.
  wcwt_block_calc u_block (
    .clk_i          (clk_i),
    .load_i         (load),
    .query_minute_i (item.query_minute),
    .day_i          (day_next),
    .block_index_o  (block_index_o)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = item_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign timed_out_o      = status.timed_out;
  assign current_second_o = status.second;
  assign current_minute_o = status.minute;
  assign update_pending_o = status.update_flag;
  assign led_off_pulse_o  = status.led_off_pulse;

endmodule

// ===== rtl/core/wcwt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the week clock, bound to the top level.
module wcwt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  current_second_o,
  input logic [13:0] current_minute_o,
  input logic        led_off_pulse_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Stall input only when the result side is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result slot");

  a_led_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && led_off_pulse_o |->
      current_second_o == 6'd0 || current_second_o == 6'd20 ||
      current_second_o == 6'd40 || current_second_o == 6'd60)
    else $error("LED pulse on a second not a multiple of twenty");

  a_minute_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(current_minute_o) |-> out_valid_o)
    else $error("minute changed without a result beat");

endmodule

bind week_clock_with_timeout wcwt_checker u_wcwt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .current_second_o (current_second_o),
  .current_minute_o (current_minute_o),
  .led_off_pulse_o  (led_off_pulse_o)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the minute-of-week clock with timeout and block query.
module tb_top;
  import wcwt_pkg::*;

  // Data constants of the clock behaviour (not codes)
  localparam int SecondsPerMinute = 60;
  localparam int FlagClearStep    = 25;
  localparam int LedOffStep       = 20;
  localparam int BlockMinutes     = 30;

  // Mode values the block does not decode; they must behave as a plain query
  localparam logic [2:0] ModeSpareFirst = 3'd5;
  localparam logic [2:0] ModeSpareLast  = 3'd7;

  localparam int RandomSteps   = 90;
  localparam int HoldOffCycles = 60;
  localparam int DrainLimit    = 1000;
  localparam int SettleCycles  = 8;

  // One result beat, in the order of the output ports
  typedef struct packed {
    logic        timed_out;
    logic [5:0]  second;
    logic [13:0] minute;
    logic        update_pending;
    logic        led_off;
    logic [7:0]  block;
  } clock_status_t;

  // Shadow of the clock state: works out the status each input beat must produce
  // and holds those statuses until the block delivers them.
  class week_clock_scoreboard;
    logic [7:0]    tick_div;
    logic [5:0]    second;
    logic [5:0]    skip_count;
    logic [13:0]   minute;
    logic [2:0]    day;
    logic [5:0]    dl_second;
    logic [13:0]   dl_minute;
    logic          flag;
    clock_status_t status_due_q[$];
    int unsigned   fails;

    function new();
      tick_div   = '0;
      second     = '0;
      skip_count = 6'd1;
      minute     = '0;
      day        = '0;
      dl_second  = '0;
      dl_minute  = '0;
      flag       = 1'b1;
      fails      = 0;
    endfunction

    function void note_beat(input item_t b);
      clock_status_t want;
      logic          pulse;
      int            total;
      int            sum;
      int            carry;
      int            diff;
      int            quot;
      pulse = 1'b0;
      case (b.mode)
        MODE_TICK: begin
          if (tick_div != TicksPerSecond) begin
            tick_div = tick_div + 8'd1;
          end else begin
            tick_div = '0;
            if (second == SecondsRoll) begin
              // minute rollover; every sixty-first one is swallowed for drift
              second = '0;
              if (skip_count == SkipRoll) begin
                skip_count = '0;
              end else begin
                skip_count = skip_count + 6'd1;
                minute = (minute == MinutesPerWeek) ? '0 : minute + 14'd1;
                if (int'(minute) % FlagClearStep == 0) flag = 1'b0;
              end
            end else begin
              // counts past sixty wrap in six bits, so zero pulses too
              second = second + 6'd1;
              pulse  = (int'(second) % LedOffStep == 0);
            end
          end
        end
        MODE_SET_TIME: begin
          total = int'(MinutesPerDay) * int'(b.set_day) + SecondsPerMinute * int'(b.set_hour)
                  + int'(b.set_minute);
          if (total >= int'(EarlyLimit)) begin
            minute = 14'(total - int'(SetTimeOffset));
          end else begin
            minute = 14'(int'(EarlyWrapBase) + total);
            day    = EarlyDay;
          end
          second = b.set_second;
        end
        MODE_SET_TIMEOUT: begin
          sum   = int'(second) + int'(b.delay_seconds) % SecondsPerMinute;
          carry = 0;
          if (sum > SecondsPerMinute - 1) begin
            carry = 1;
            sum   = sum - SecondsPerMinute;
          end
          dl_second = 6'(sum);
          dl_minute = 14'(int'(minute) + int'(b.delay_seconds) / SecondsPerMinute + carry);
        end
        MODE_WRITE_FLAG: flag = b.flag_value;
        default: ;
      endcase
      // signed division truncates toward zero, then keep the low byte
      diff = int'(b.query_minute) - int'(day) * int'(MinutesPerDay);
      quot = diff / BlockMinutes;
      want.timed_out      = (second >= dl_second) && (minute >= dl_minute);
      want.second         = second;
      want.minute         = minute;
      want.update_pending = flag;
      want.led_off        = pulse;
      want.block          = 8'(quot);
      status_due_q.push_back(want);
    endfunction

    function void check_status(input clock_status_t got);
      clock_status_t want;
      string         diffs;
      if (status_due_q.size() == 0) begin
        fails++;
        $display("%0t: status beat with nothing expected: to=%0b s=%0d m=%0d up=%0b led=%0b blk=%0d",
                 $time, got.timed_out, got.second, got.minute, got.update_pending,
                 got.led_off, got.block);
        return;
      end
      want  = status_due_q.pop_front();
      diffs = "";
      if (got.timed_out !== want.timed_out)           diffs = {diffs, " timed_out"};
      if (got.second !== want.second)                 diffs = {diffs, " current_second"};
      if (got.minute !== want.minute)                 diffs = {diffs, " current_minute"};
      if (got.update_pending !== want.update_pending) diffs = {diffs, " update_pending"};
      if (got.led_off !== want.led_off)               diffs = {diffs, " led_off_pulse"};
      if (got.block !== want.block)                   diffs = {diffs, " block_index"};
      if (diffs != "") begin
        fails++;
        $display("%0t: mismatch on%s: expected to=%0b s=%0d m=%0d up=%0b led=%0b blk=%0d",
                 $time, diffs, want.timed_out, want.second, want.minute,
                 want.update_pending, want.led_off, want.block);
        $display("%0t:   actual           to=%0b s=%0d m=%0d up=%0b led=%0b blk=%0d",
                 $time, got.timed_out, got.second, got.minute, got.update_pending,
                 got.led_off, got.block);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall_o;
  item_t         beat_q;
  logic          out_valid_o;
  logic          out_stall;
  logic          timed_out_o;
  logic [5:0]    current_second_o;
  logic [13:0]   current_minute_o;
  logic          update_pending_o;
  logic          led_off_pulse_o;
  logic [7:0]    block_index_o;

  week_clock_scoreboard sb;

  // Idling odds in percent, changed at phase boundaries by the stimulus
  int send_idle_pct = 29;
  int stall_pct     = 60;
  // Cycles the receiver still has to hold off; counted down by the receiver itself
  int hold_left     = 0;
  // Sender-side copy of the tick divider, used to aim tick bursts at a second boundary
  int tick_phase    = 0;

  week_clock_with_timeout DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .mode_i           (beat_q.mode),
    .set_day_i        (beat_q.set_day),
    .set_hour_i       (beat_q.set_hour),
    .set_minute_i     (beat_q.set_minute),
    .set_second_i     (beat_q.set_second),
    .delay_seconds_i  (beat_q.delay_seconds),
    .query_minute_i   (beat_q.query_minute),
    .flag_value_i     (beat_q.flag_value),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .timed_out_o      (timed_out_o),
    .current_second_o (current_second_o),
    .current_minute_o (current_minute_o),
    .update_pending_o (update_pending_o),
    .led_off_pulse_o  (led_off_pulse_o),
    .block_index_o    (block_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or stalls for good
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch when asked
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Monitor both channels; everything sampled here holds its pre-edge value
  always @(posedge clk_i) begin
    clock_status_t seen;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_beat(beat_q);
      if (out_valid_o && !out_stall) begin
        seen = {timed_out_o, current_second_o, current_minute_o, update_pending_o,
                led_off_pulse_o, block_index_o};
        sb.check_status(seen);
      end
    end
  end

  // Random beat of the given mode; the query minute mostly stays inside the week
  function automatic item_t make_beat(input logic [2:0] mode);
    logic [63:0] raw;
    item_t       b;
    raw    = {$urandom, $urandom};
    b      = raw[$bits(item_t)-1:0];
    b.mode = mode;
    if ($urandom_range(3) != 0) b.query_minute = 14'($urandom_range(int'(MinutesPerWeek)));
    return b;
  endfunction

  // Offer one beat after a random gap and hold it until it is taken
  task automatic send_beat(input item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    beat_q   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (b.mode == MODE_TICK) begin
      tick_phase = (tick_phase == int'(TicksPerSecond)) ? 0 : tick_phase + 1;
    end
  endtask

  // Send a run of ticks, now and then broken up by some other beat
  task automatic send_ticks(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(49) == 0) begin
        send_beat(make_beat(3'($urandom_range(ModeSpareLast, MODE_SET_TIME))));
      end
      send_beat(make_beat(MODE_TICK));
    end
  endtask

  initial begin
    item_t b;
    int    drain;
    sb = new();
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    beat_q   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: query limits straight out of reset, one tick, flag writes
    b = make_beat(MODE_QUERY);
    b.query_minute = '0;
    send_beat(b);
    b.query_minute = '1;
    send_beat(b);
    send_beat(make_beat(MODE_TICK));
    b = make_beat(MODE_WRITE_FLAG);
    b.flag_value = 1'b0;
    send_beat(b);
    b.flag_value = 1'b1;
    send_beat(b);
    // undecoded modes act as a query
    send_beat(make_beat(ModeSpareFirst));
    send_beat(make_beat(ModeSpareLast));
    // earliest time of the week: wraps into day six
    b = make_beat(MODE_SET_TIME);
    {b.set_day, b.set_hour, b.set_minute, b.set_second} = '0;
    send_beat(b);
    // block query with a negative difference
    b = make_beat(MODE_QUERY);
    b.query_minute = '0;
    send_beat(b);
    // every set-time field at its maximum: minute lands beyond the week, second above sixty
    b = make_beat(MODE_SET_TIME);
    {b.set_day, b.set_hour, b.set_minute, b.set_second} = '1;
    send_beat(b);
    // either side of the early-wrap threshold
    {b.set_day, b.set_hour, b.set_minute, b.set_second} = {3'd0, 5'd5, 6'd0, 6'd30};
    send_beat(b);
    {b.set_day, b.set_hour, b.set_minute, b.set_second} = {3'd0, 5'd4, 6'd59, 6'd59};
    send_beat(b);
    // deadlines: zero delay, full delay, and a second carry into the minute
    b = make_beat(MODE_SET_TIMEOUT);
    b.delay_seconds = '0;
    send_beat(b);
    b.delay_seconds = '1;
    send_beat(b);
    b.delay_seconds = 16'd59;
    send_beat(b);
    // park on the last minute of the week, about to roll over
    b = make_beat(MODE_SET_TIME);
    {b.set_day, b.set_hour, b.set_minute, b.set_second} = {3'd7, 5'd8, 6'd0, SecondsRoll};
    send_beat(b);
    send_ticks(3);

    // Random part in three idling phases
    for (int i = 0; i < RandomSteps; i++) begin
      if (i == RandomSteps / 3) begin
        send_idle_pct = 60;
        stall_pct     = 29;
      end
      if (i == 2 * RandomSteps / 3) begin
        // no idling from here; start with a long hold-off so the block backs up
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HoldOffCycles;
      end
      if (i == RandomSteps / 3 || i == 2 * RandomSteps / 3) begin
        // Well-formed sequence at each phase change: set a time, often close to a boundary,
        // maybe arm a deadline, then tick just past the next second so a rollover or
        // pulse really happens
        b = make_beat(MODE_SET_TIME);
        case ($urandom_range(3))
          0: {b.set_day, b.set_hour, b.set_minute} = {3'd7, 5'd8, 6'd0};   // end of week
          1: {b.set_day, b.set_hour, b.set_minute} = {3'd0, 5'd7, 6'd59};  // top of 14 bits
          default: ;
        endcase
        case ($urandom_range(7))
          0: b.set_second = 6'd59;
          1: b.set_second = 6'($urandom_range(63, 61));
          2: ;
          default: b.set_second = SecondsRoll;
        endcase
        send_beat(b);
        if ($urandom_range(2) == 0) begin
          b = make_beat(MODE_SET_TIMEOUT);
          b.delay_seconds = 16'($urandom_range(120));
          send_beat(b);
        end
        send_ticks(int'(TicksPerSecond) + 1 - tick_phase + int'($urandom_range(3)));
      end else begin
        case ($urandom_range(9))
          0, 1, 2: send_ticks(int'($urandom_range(5, 1)));
          3:       send_beat(make_beat(MODE_SET_TIME));
          4:       send_beat(make_beat(MODE_SET_TIMEOUT));
          5:       send_beat(make_beat(MODE_QUERY));
          6, 7:    send_beat(make_beat(MODE_WRITE_FLAG));
          default: send_beat(make_beat(3'($urandom_range(ModeSpareLast, ModeSpareFirst))));
        endcase
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for outstanding status beats, then watch a little longer for strays
    for (drain = 0; drain < DrainLimit && sb.status_due_q.size() != 0; drain++) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.status_due_q.size() != 0) begin
      $display("%0t: %0d expected status beats never arrived", $time, sb.status_due_q.size());
    end
    if (sb.fails == 0 && sb.status_due_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wcwt_pkg.sv
rtl/core/wcwt_input_stage.sv
rtl/core/wcwt_clock_core.sv
rtl/core/wcwt_block_calc.sv
rtl/core/week_clock_with_timeout.sv
rtl/core/wcwt_checker.sv
test/tb_top.sv
